// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL that carries concurrent checks.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Implication that must hold at every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/chtab_pkg.sv =====
// Constants and codes for the chained hash table.
// No dependencies.
`timescale 1ns / 1ps

package chtab_pkg;
   localparam int BUCKET_BITS  = 12;
   localparam int BUCKETS      = 4096;
   localparam int IDX_BITS     = 10;
   localparam int POOL_ENTRIES = 1024;
   localparam int PTR_BITS     = 11;
   localparam int KEY_BITS     = 32;
   localparam int VALUE_BITS   = 32;

   localparam logic [PTR_BITS-1:0] END_MARK = PTR_BITS'(POOL_ENTRIES);

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_FIND   = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;

   localparam logic [1:0] STATUS_DONE   = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_ABSENT = 2'd2;
endpackage

// ===== rtl/chained_hash_table.sv =====
// States from accept: insert S_BKT, S_INS2 (non-empty chain only), S_DONE; full pool
// or unused mode S_DONE; find/delete S_BKT, S_WALK per entry walked (none for an empty
// bucket), S_DEL1 and S_DEL2 on a delete hit, S_DONE until the output is free.
// Throughput: one transaction at a time; the chain walk reads one entry per cycle
// through the entry memories' single read port, so the rate follows chain length.
// Reset (synchronous): a clearing pass over all 4096 buckets empties every bucket and
// rebuilds the free list; no transaction is accepted until it ends.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chained_hash_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_mode,
   input  logic [chtab_pkg::KEY_BITS-1:0]    req_key,
   input  logic [chtab_pkg::VALUE_BITS-1:0]  req_item_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [chtab_pkg::VALUE_BITS-1:0]  rsp_found_value,
   output logic [1:0]                        rsp_status
);

   localparam int PB = chtab_pkg::PTR_BITS;
   localparam int IB = chtab_pkg::IDX_BITS;
   localparam int BB = chtab_pkg::BUCKET_BITS;
   localparam int KB = chtab_pkg::KEY_BITS;
   localparam int VB = chtab_pkg::VALUE_BITS;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_BKT   = 4'd2;
   localparam logic [3:0] S_INS2  = 4'd3;
   localparam logic [3:0] S_WALK  = 4'd4;
   localparam logic [3:0] S_DEL1  = 4'd5;
   localparam logic [3:0] S_DEL2  = 4'd6;
   localparam logic [3:0] S_DONE  = 4'd7;

   // Memories: bucket table {used, head}, key/value, next links, prev links
   logic [PB:0]      bkt_mem  [chtab_pkg::BUCKETS];
   logic [KB+VB-1:0] kv_mem   [chtab_pkg::POOL_ENTRIES];
   logic [PB-1:0]    next_mem [chtab_pkg::POOL_ENTRIES];
   logic [PB-1:0]    prev_mem [chtab_pkg::POOL_ENTRIES];

   logic [PB:0]      bkt_rd_ff;
   logic [KB+VB-1:0] kv_rd_ff;
   logic [PB-1:0]    next_rd_ff;
   logic [PB-1:0]    prev_rd_ff;

   logic [BB-1:0]    bkt_raddr, bkt_waddr;
   logic [PB:0]      bkt_wdata;
   logic             bkt_we;
   logic [IB-1:0]    ent_raddr;
   logic             kv_we, next_we, prev_we;
   logic [IB-1:0]    next_waddr, prev_waddr;
   logic [PB-1:0]    next_wdata, prev_wdata;

   // Control and transaction registers
   logic [3:0]    state_ff, state_in;
   logic [BB-1:0] clr_ff, clr_in;
   logic [PB-1:0] free_head_ff, free_head_in;
   logic [PB-1:0] free_count_ff, free_count_in;
   logic [1:0]    mode_ff, mode_in;
   logic [KB-1:0] key_ff, key_in;
   logic [VB-1:0] val_ff, val_in;
   logic [PB-1:0] cur_ff, cur_in;
   logic [PB-1:0] prv_ff, prv_in;
   logic [PB-1:0] nxt_ff, nxt_in;
   logic          res_hit_ff, res_hit_in;
   logic [VB-1:0] res_fv_ff, res_fv_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_hit_ff, rsp_hit_in;
   logic [VB-1:0] rsp_fv_ff, rsp_fv_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   logic          bkt_used;
   logic [PB-1:0] bkt_head;
   logic          key_match;
   logic          out_free;

   assign bkt_used  = bkt_rd_ff[PB];
   assign bkt_head  = bkt_rd_ff[PB-1:0];
   assign key_match = (kv_rd_ff[KB+VB-1:VB] == key_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_found_value = rsp_fv_ff;
   assign rsp_status      = rsp_status_ff;

   // Read addresses: the walk follows the next link straight from the read data
   always_comb begin
      bkt_raddr = (state_ff == S_IDLE) ? req_key[BB-1:0] : key_ff[BB-1:0];
      unique case (state_ff)
         S_IDLE:  ent_raddr = free_head_ff[IB-1:0];
         S_BKT:   ent_raddr = bkt_head[IB-1:0];
         S_WALK:  ent_raddr = next_rd_ff[IB-1:0];
         default: ent_raddr = cur_ff[IB-1:0];
      endcase
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      cur_in        = cur_ff;
      prv_in        = prv_ff;
      nxt_in        = nxt_ff;
      res_hit_in    = res_hit_ff;
      res_fv_in     = res_fv_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_fv_in     = rsp_fv_ff;
      rsp_status_in = rsp_status_ff;

      bkt_we     = 1'b0;
      bkt_waddr  = key_ff[BB-1:0];
      bkt_wdata  = '0;
      kv_we      = 1'b0;
      next_we    = 1'b0;
      next_waddr = cur_ff[IB-1:0];
      next_wdata = chtab_pkg::END_MARK;
      prev_we    = 1'b0;
      prev_waddr = cur_ff[IB-1:0];
      prev_wdata = chtab_pkg::END_MARK;

      unique case (state_ff)
         S_CLEAR: begin
            // Empty one bucket a cycle; rebuild the free list alongside
            bkt_we    = 1'b1;
            bkt_waddr = clr_ff;
            if (clr_ff < BB'(chtab_pkg::POOL_ENTRIES)) begin
               next_we    = 1'b1;
               next_waddr = clr_ff[IB-1:0];
               next_wdata = clr_ff[PB-1:0] + PB'(1);
            end
            clr_in = clr_ff + BB'(1);
            if (clr_ff == BB'(chtab_pkg::BUCKETS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            res_hit_in    = 1'b0;
            res_fv_in     = '0;
            res_status_in = chtab_pkg::STATUS_DONE;
            if (req_valid) begin
               mode_in = req_mode;
               key_in  = req_key;
               val_in  = req_item_value;
               cur_in  = free_head_ff;
               if (req_mode == chtab_pkg::MODE_INSERT) begin
                  if (free_count_ff == '0 || free_head_ff >= chtab_pkg::END_MARK) begin
                     res_status_in = chtab_pkg::STATUS_FULL;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_BKT;
                  end
               end else if (req_mode == chtab_pkg::MODE_FIND ||
                            req_mode == chtab_pkg::MODE_DELETE) begin
                  state_in = S_BKT;
               end else begin
                  state_in = S_DONE;  // unused mode: plain done
               end
            end
         end
         S_BKT: begin
            if (mode_ff == chtab_pkg::MODE_INSERT) begin
               // Link the free head entry in front of the chain
               kv_we         = 1'b1;
               next_we       = 1'b1;
               next_wdata    = bkt_used ? bkt_head : chtab_pkg::END_MARK;
               prev_we       = 1'b1;
               bkt_we        = 1'b1;
               bkt_wdata     = {1'b1, cur_ff};
               free_head_in  = next_rd_ff;
               free_count_in = free_count_ff - PB'(1);
               nxt_in        = bkt_head;
               if (bkt_used && bkt_head < chtab_pkg::END_MARK) state_in = S_INS2;
               else                                              state_in = S_DONE;
            end else if (!bkt_used) begin
               res_status_in = chtab_pkg::STATUS_ABSENT;
               state_in      = S_DONE;
            end else begin
               cur_in   = bkt_head;
               state_in = S_WALK;
            end
         end
         S_INS2: begin
            prev_we    = 1'b1;
            prev_waddr = nxt_ff[IB-1:0];
            prev_wdata = cur_ff;
            state_in   = S_DONE;
         end
         S_WALK: begin
            if (key_match) begin
               res_hit_in = 1'b1;
               if (mode_ff == chtab_pkg::MODE_FIND) begin
                  res_fv_in = kv_rd_ff[VB-1:0];
                  state_in  = S_DONE;
               end else begin
                  prv_in   = prev_rd_ff;
                  nxt_in   = next_rd_ff;
                  state_in = S_DEL1;
               end
            end else if (next_rd_ff >= chtab_pkg::END_MARK) begin
               res_status_in = chtab_pkg::STATUS_ABSENT;
               state_in      = S_DONE;
            end else begin
               cur_in = next_rd_ff;
            end
         end
         S_DEL1: begin
            // Unlink: bypass from the previous entry, or move or clear the bucket head
            if (prv_ff < chtab_pkg::END_MARK) begin
               next_we    = 1'b1;
               next_waddr = prv_ff[IB-1:0];
               next_wdata = nxt_ff;
            end else if (nxt_ff < chtab_pkg::END_MARK) begin
               bkt_we    = 1'b1;
               bkt_wdata = {1'b1, nxt_ff};
            end else begin
               bkt_we    = 1'b1;
               bkt_wdata = '0;
            end
            if (nxt_ff < chtab_pkg::END_MARK) begin
               prev_we    = 1'b1;
               prev_waddr = nxt_ff[IB-1:0];
               prev_wdata = prv_ff;
            end
            state_in = S_DEL2;
         end
         S_DEL2: begin
            // Return the entry to the head of the free list
            next_we      = 1'b1;
            next_wdata   = free_head_ff;
            prev_we      = 1'b1;
            free_head_in = cur_ff;
            if (free_count_ff < chtab_pkg::END_MARK) free_count_in = free_count_ff + PB'(1);
            state_in = S_DONE;
         end
         S_DONE: begin
            // Hold the result until the output register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = res_hit_ff;
               rsp_fv_in     = res_fv_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Memory ports
   always_ff @(posedge clock) begin
      if (bkt_we) bkt_mem[bkt_waddr] <= bkt_wdata;
      bkt_rd_ff <= bkt_mem[bkt_raddr];
   end

   always_ff @(posedge clock) begin
      if (kv_we) kv_mem[cur_ff[IB-1:0]] <= {key_ff, val_ff};
      kv_rd_ff <= kv_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_waddr] <= next_wdata;
      next_rd_ff <= next_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
      prev_rd_ff <= prev_mem[ent_raddr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         free_head_ff  <= '0;
         free_count_ff <= chtab_pkg::END_MARK;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      prv_ff        <= prv_in;
      nxt_ff        <= nxt_in;
      res_hit_ff    <= res_hit_in;
      res_fv_ff     <= res_fv_in;
      res_status_ff <= res_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_fv_ff     <= rsp_fv_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Checks
   `ASSERT_ALWAYS(a_count_range, clock, reset, free_count_ff <= chtab_pkg::END_MARK)
   `ASSERT_IMPLY(a_empty_pool, clock, reset, free_count_ff == '0,
                 free_head_ff == chtab_pkg::END_MARK)
   `ASSERT_IMPLY(a_walk_cursor, clock, reset, state_ff == S_WALK,
                 cur_ff < chtab_pkg::END_MARK)

endmodule
